// ===== design/bol_pkg.sv =====
package bol_pkg;

    // Widths fixed by the item fields.
    localparam int IDX_W    = 11;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 4'd0,
        MODE_PUSH_BACK  = 4'd1,
        MODE_AFTER_KEY  = 4'd2,
        MODE_AFTER_POS  = 4'd3,
        MODE_POP_FRONT  = 4'd4,
        MODE_POP_BACK   = 4'd5,
        MODE_DELETE_KEY = 4'd6,
        MODE_SEARCH     = 4'd7,
        MODE_READ_OUT   = 4'd8
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INVALID   = 3'd3,
        ST_RANGE     = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;   // insert or remove position
        logic [IDX_W-1:0] last;  // index of the final valid entry
    } t_cell_cmd;

endpackage

// ===== design/bol_cell.sv =====
module bol_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  bol_pkg::t_cell_cmd         i_cmd,
    input  logic [bol_pkg::IDX_W-1:0]  i_index,
    input  logic [DATA_WIDTH-1:0]      i_left,
    input  logic [DATA_WIDTH-1:0]      i_right,
    input  logic [DATA_WIDTH-1:0]      i_head,
    input  logic [DATA_WIDTH-1:0]      i_value,
    output logic [DATA_WIDTH-1:0]      o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            bol_pkg::CELL_INSERT: begin
                // open a gap at idx, push the tail one cell back
                if (i_index == i_cmd.idx) begin
                    n_data = i_value;
                end else if (i_index > i_cmd.idx) begin
                    n_data = i_left;
                end
            end
            bol_pkg::CELL_REMOVE: begin
                if (i_index >= i_cmd.idx) begin
                    n_data = i_right;
                end
            end
            bol_pkg::CELL_ROTATE: begin
                // head wraps around to the last valid cell
                if (i_index == i_cmd.last) begin
                    n_data = i_head;
                end else if (i_index < i_cmd.last) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== design/bounded_ordered_list_unit.sv =====
// Bounded ordered list of up to DEPTH signed words, held in a chain of cells
// with the front of the list in cell 0. Each accepted word carries a mode
// (push front/back, insert after key, insert after position, pop front/back,
// delete key, search, read out) and answers with one result word, except
// read out of a non-empty list, which returns one word per entry with the
// last one marked. Data only moves between neighboring cells: inserts and
// deletes shift part of the chain by one cell at once, while a key lookup
// rotates the whole list past the comparator at cell 0, one entry per cycle,
// and leaves it in its original order. Modes that need no key lookup, and
// key modes on an empty list, pass from acceptance through the execute
// state, which loads the result register; insert after key, delete key and
// search first rotate the N entries past the head comparator in the scan
// state. Read out passes through the execute state into the read state,
// which loads one word per cycle while the output register can take it, N
// words in all. A step that loads a result waits while the output register
// still holds a word the consumer has not taken. The input side is ready
// again as soon as the final result is loaded into the output register, so
// a new word is taken while that result still waits for the consumer.
module bounded_ordered_list_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_mode,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    input  logic signed [7:0]  i_position,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic               o_found,
    output logic [10:0]        o_hit_position,
    output logic signed [31:0] o_entry,
    output logic [10:0]        o_occupancy,
    output logic               o_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int IDX_W = bol_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_READ = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // latched command word
    logic [3:0]         r_mode;
    logic signed [31:0] r_key;
    logic signed [31:0] r_value;
    logic [7:0]         r_pos;

    // list bookkeeping
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_scan;
    logic [CNT_W-1:0] n_scan;
    logic [CNT_W-1:0] r_hit;
    logic [CNT_W-1:0] n_hit;
    logic             r_found;
    logic             n_found;

    // output register
    logic             r_ov;
    bol_pkg::t_status r_status;
    logic             r_found_out;
    logic [10:0]      r_hit_pos;
    logic [31:0]      r_entry;
    logic [10:0]      r_occ;
    logic             r_last;

    // result being loaded this cycle
    logic             w_emit;
    bol_pkg::t_status e_status;
    logic             e_found;
    logic [10:0]      e_hit_pos;
    logic [31:0]      e_entry;
    logic             e_last;

    logic                  w_in_accept;
    logic                  w_slot;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_key_mode;
    logic [CNT_W-1:0]      w_count_m1;
    logic [CMP_W-1:0]      w_pidx;
    logic [DATA_WIDTH-1:0] w_key_word;
    logic [DATA_WIDTH-1:0] w_val_word;
    logic [DATA_WIDTH-1:0] w_head;
    bol_pkg::t_cell_cmd    w_cmd;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    // the output register can take a word when empty or being drained
    assign w_slot      = !r_ov || i_out_ready;

    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_key_word = DATA_WIDTH'(r_key);
    assign w_val_word = DATA_WIDTH'(r_value);
    assign w_head     = w_data[0];
    // insert-after-position target: position, but never before index 1
    assign w_pidx     = (r_pos[6:0] == 7'd0) ? CMP_W'(1) : CMP_W'(r_pos[6:0]);

    assign w_key_mode = (i_mode == bol_pkg::MODE_AFTER_KEY)
                     || (i_mode == bol_pkg::MODE_DELETE_KEY)
                     || (i_mode == bol_pkg::MODE_SEARCH);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_scan    = r_scan;
        n_hit     = r_hit;
        n_found   = r_found;
        w_cmd     = '{op: bol_pkg::CELL_HOLD, idx: '0, last: IDX_W'(w_count_m1)};
        w_emit    = 1'b0;
        e_status  = bol_pkg::ST_OK;
        e_found   = 1'b0;
        e_hit_pos = '0;
        e_entry   = '0;
        e_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_scan  = '0;
                    n_found = 1'b0;
                    n_hit   = '0;
                    // key lookups rotate the list first unless it is empty
                    if (w_key_mode && !w_empty) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end

            S_SCAN: begin
                // rotate one entry past the head comparator, keep the first hit
                w_cmd.op = bol_pkg::CELL_ROTATE;
                if ((w_head == w_key_word) && !r_found) begin
                    n_found = 1'b1;
                    n_hit   = r_scan;
                end
                n_scan = r_scan + CNT_W'(1);
                if (r_scan == w_count_m1) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    case (r_mode)
                        bol_pkg::MODE_PUSH_FRONT,
                        bol_pkg::MODE_PUSH_BACK: begin
                            if (w_full) begin
                                e_status = bol_pkg::ST_FULL;
                            end else begin
                                w_cmd.op  = bol_pkg::CELL_INSERT;
                                w_cmd.idx = (r_mode == bol_pkg::MODE_PUSH_FRONT) ?
                                            '0 : IDX_W'(r_count);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        bol_pkg::MODE_AFTER_KEY: begin
                            if (w_empty) begin
                                w_cmd.op  = bol_pkg::CELL_INSERT;
                                w_cmd.idx = '0;
                                n_count   = r_count + CNT_W'(1);
                            end else if (!r_found) begin
                                e_status = bol_pkg::ST_NOT_FOUND;
                            end else if (w_full) begin
                                e_status = bol_pkg::ST_FULL;
                            end else begin
                                w_cmd.op  = bol_pkg::CELL_INSERT;
                                w_cmd.idx = IDX_W'(r_hit) + IDX_W'(1);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        bol_pkg::MODE_AFTER_POS: begin
                            if (r_pos[7]) begin
                                e_status = bol_pkg::ST_INVALID;
                            end else if (w_empty) begin
                                w_cmd.op  = bol_pkg::CELL_INSERT;
                                w_cmd.idx = '0;
                                n_count   = r_count + CNT_W'(1);
                            end else if (w_pidx > CMP_W'(r_count)) begin
                                e_status = bol_pkg::ST_RANGE;
                            end else if (w_full) begin
                                e_status = bol_pkg::ST_FULL;
                            end else begin
                                w_cmd.op  = bol_pkg::CELL_INSERT;
                                w_cmd.idx = IDX_W'(w_pidx);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        bol_pkg::MODE_POP_FRONT,
                        bol_pkg::MODE_POP_BACK: begin
                            if (w_empty) begin
                                e_status = bol_pkg::ST_EMPTY;
                            end else begin
                                w_cmd.op  = bol_pkg::CELL_REMOVE;
                                w_cmd.idx = (r_mode == bol_pkg::MODE_POP_FRONT) ?
                                            '0 : IDX_W'(w_count_m1);
                                n_count   = w_count_m1;
                            end
                        end
                        bol_pkg::MODE_DELETE_KEY: begin
                            if (w_empty) begin
                                e_status = bol_pkg::ST_EMPTY;
                            end else if (!r_found) begin
                                e_status = bol_pkg::ST_NOT_FOUND;
                            end else begin
                                w_cmd.op  = bol_pkg::CELL_REMOVE;
                                w_cmd.idx = IDX_W'(r_hit);
                                n_count   = w_count_m1;
                            end
                        end
                        bol_pkg::MODE_SEARCH: begin
                            if (w_empty) begin
                                e_status = bol_pkg::ST_EMPTY;
                            end else if (!r_found) begin
                                e_status = bol_pkg::ST_NOT_FOUND;
                            end else begin
                                e_found   = 1'b1;
                                e_hit_pos = 11'(r_hit) + 11'd1;
                            end
                        end
                        bol_pkg::MODE_READ_OUT: begin
                            if (w_empty) begin
                                e_status = bol_pkg::ST_EMPTY;
                            end else begin
                                // hold; entries stream out from the read state
                                w_emit  = 1'b0;
                                n_scan  = '0;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            e_status = bol_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_READ: begin
                if (w_slot) begin
                    // emit the head and rotate it to the back
                    w_emit   = 1'b1;
                    w_cmd.op = bol_pkg::CELL_ROTATE;
                    e_entry  = 32'(w_head);
                    e_last   = (r_scan == w_count_m1);
                    n_scan   = r_scan + CNT_W'(1);
                    if (r_scan == w_count_m1) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_scan  <= '0;
            r_hit   <= '0;
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_scan  <= n_scan;
            r_hit   <= n_hit;
            r_found <= n_found;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload: latch the command word and the result word.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_mode  <= i_mode;
            r_key   <= i_key;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (w_emit) begin
            r_status    <= e_status;
            r_found_out <= e_found;
            r_hit_pos   <= e_hit_pos;
            r_entry     <= e_entry;
            r_occ       <= 11'(n_count);
            r_last      <= e_last;
        end
    end

    // Chain of cells, cell 0 holds the front of the list.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_val_word;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        bol_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_head),
            .i_value (w_val_word),
            .o_data  (w_data[g])
        );
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_status;
    assign o_found        = r_found_out;
    assign o_hit_position = r_hit_pos;
    assign o_entry        = r_entry;
    assign o_occupancy    = r_occ;
    assign o_last         = r_last;

`ifndef SYNTHESIS
    // occupancy never leaves the list bounds
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("list count above DEPTH");

    // scan and read out only walk over valid entries
    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_READ) |-> (r_scan < r_count))
        else $error("scan index beyond list");

    // an idle block with no new word keeps its list
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !w_in_accept) |=> $stable(r_count))
        else $error("list count changed while idle");

    // a result is only loaded into a free or draining output register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_ov || i_out_ready))
        else $error("result loaded over a pending word");
`endif

endmodule
